// File: design/block_range_max_position_macros.svh
// Assertion macros for the block_range_max_position design.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BLOCK_RANGE_MAX_POSITION_MACROS_SVH
`define BLOCK_RANGE_MAX_POSITION_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define BRMP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check a property on every clock edge, reset included.
`define BRMP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");
`else
`define BRMP_ASSERT(lbl, clk, rst_n, prop)
`define BRMP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: design/brmp_pkg.sv
// Shared types for the block_range_max_position design.
// Depends on nothing; used by brmp_cell and the top level.
`timescale 1ns / 1ps

package brmp_pkg;

	// Control flags that travel with each beat along the cell row.
	typedef struct packed {
		logic valid;
		logic err;
	} cell_ctl_t;

endpackage

// File: design/brmp_cell.sv
// One cell of the range-maximum row: applies step IDX of the prefix walk.
// Depends on brmp_pkg for the control struct.
`timescale 1ns / 1ps

module brmp_cell import brmp_pkg::*; #(
	parameter int BLOCK_BITS = 8,
	parameter int IDX        = 0
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  cell_ctl_t                                  up_ctl,
	input  logic [BLOCK_BITS-1:0]                      up_shape,
	input  logic [$clog2(BLOCK_BITS)-1:0]              up_lo,
	input  logic [$clog2(BLOCK_BITS)-1:0]              up_hi,
	input  logic signed [$clog2(BLOCK_BITS+1):0]       up_level,
	input  logic signed [$clog2(BLOCK_BITS+1):0]       up_best,
	input  logic [$clog2(BLOCK_BITS)-1:0]              up_pos,
	output logic                                       up_ready,
	output cell_ctl_t                                  dn_ctl,
	output logic [BLOCK_BITS-1:0]                      dn_shape,
	output logic [$clog2(BLOCK_BITS)-1:0]              dn_lo,
	output logic [$clog2(BLOCK_BITS)-1:0]              dn_hi,
	output logic signed [$clog2(BLOCK_BITS+1):0]       dn_level,
	output logic signed [$clog2(BLOCK_BITS+1):0]       dn_best,
	output logic [$clog2(BLOCK_BITS)-1:0]              dn_pos,
	input  logic                                       dn_ready
);

	localparam int POS_W = $clog2(BLOCK_BITS);
	localparam int LVL_W = $clog2(BLOCK_BITS + 1) + 1;
	localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);
	localparam logic signed [LVL_W-1:0] ONE = LVL_W'(1);

	cell_ctl_t                 ctl_q;
	logic [BLOCK_BITS-1:0]     shape_q;
	logic [POS_W-1:0]          lo_q;
	logic [POS_W-1:0]          hi_q;
	logic signed [LVL_W-1:0]   level_q;
	logic signed [LVL_W-1:0]   best_q;
	logic [POS_W-1:0]          pos_q;

	logic                      active;
	logic                      take;
	logic signed [LVL_W-1:0]   step_level;

	always_comb begin
		active     = !up_ctl.err && (IDX_P <= up_hi);
		step_level = up_shape[IDX] ? up_level + ONE : up_level - ONE;
		// first element of the range always wins; later ones only on a strict rise
		take       = active && ((IDX_P == up_lo) ||
			((IDX_P > up_lo) && (step_level > up_best)));
	end

	// Hold while the neighbor downstream stalls and this cell is full.
	assign up_ready = !ctl_q.valid || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (up_ready) begin
			ctl_q <= up_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_ctl.valid) begin
			shape_q <= up_shape;
			lo_q    <= up_lo;
			hi_q    <= up_hi;
			level_q <= active ? step_level : up_level;
			best_q  <= take ? step_level : up_best;
			pos_q   <= take ? IDX_P : up_pos;
		end
	end

	assign dn_ctl   = ctl_q;
	assign dn_shape = shape_q;
	assign dn_lo    = lo_q;
	assign dn_hi    = hi_q;
	assign dn_level = level_q;
	assign dn_best  = best_q;
	assign dn_pos   = pos_q;

endmodule

// File: design/block_range_max_position.sv
// Top level of the in-block range-maximum query engine (plus/minus-one kind).
// Depends on brmp_pkg, brmp_cell and block_range_max_position_macros.svh.
`timescale 1ns / 1ps
`include "block_range_max_position_macros.svh"

// A query gives a shape bitmap and an inclusive range [range_low, range_high];
// the result is the first position of the largest prefix value in the range,
// or 0 with range_error set when range_low exceeds range_high or range_high is
// BLOCK_BITS or more. Queries run through a row of BLOCK_BITS cells, one per
// block position, each applying one step of the prefix walk and registering
// it, so a result passes through each cell's register in turn, and one query is
// taken every cycle while the row is not backed up. The last cell's register
// is the output register; a stalled result backs up the row one cell at a
// time, so bubbles still fill behind it.
module block_range_max_position import brmp_pkg::*; #(
	parameter int BLOCK_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          query_valid,
	output logic                          query_ready,
	input  logic [BLOCK_BITS-1:0]         shape_bitmap,
	input  logic [$clog2(BLOCK_BITS)-1:0] range_low,
	input  logic [$clog2(BLOCK_BITS)-1:0] range_high,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [$clog2(BLOCK_BITS)-1:0] max_position,
	output logic                          range_error
);

	localparam int POS_W = $clog2(BLOCK_BITS);
	localparam int LVL_W = $clog2(BLOCK_BITS + 1) + 1;

	cell_ctl_t                 ctl   [0:BLOCK_BITS];
	logic [BLOCK_BITS-1:0]     shape [0:BLOCK_BITS];
	logic [POS_W-1:0]          lo    [0:BLOCK_BITS];
	logic [POS_W-1:0]          hi    [0:BLOCK_BITS];
	logic signed [LVL_W-1:0]   level [0:BLOCK_BITS];
	logic signed [LVL_W-1:0]   best  [0:BLOCK_BITS];
	logic [POS_W-1:0]          pos   [0:BLOCK_BITS];
	logic                      rdy   [0:BLOCK_BITS];

	// Flag a reversed range or one that runs past the block at entry.
	assign ctl[0].valid = query_valid;
	assign ctl[0].err   = (range_low > range_high) ||
		({1'b0, range_high} >= (POS_W + 1)'(BLOCK_BITS));
	assign shape[0]     = shape_bitmap;
	assign lo[0]        = range_low;
	assign hi[0]        = range_high;
	assign level[0]     = '0;
	assign best[0]      = '0;
	assign pos[0]       = '0;
	assign query_ready  = rdy[0];

	for (genvar j = 0; j < BLOCK_BITS; j++) begin : g_cell
		brmp_cell #(
			.BLOCK_BITS(BLOCK_BITS),
			.IDX       (j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_ctl   (ctl[j]),
			.up_shape (shape[j]),
			.up_lo    (lo[j]),
			.up_hi    (hi[j]),
			.up_level (level[j]),
			.up_best  (best[j]),
			.up_pos   (pos[j]),
			.up_ready (rdy[j]),
			.dn_ctl   (ctl[j+1]),
			.dn_shape (shape[j+1]),
			.dn_lo    (lo[j+1]),
			.dn_hi    (hi[j+1]),
			.dn_level (level[j+1]),
			.dn_best  (best[j+1]),
			.dn_pos   (pos[j+1]),
			.dn_ready (rdy[j+1])
		);
	end

	assign rdy[BLOCK_BITS] = result_ready;
	assign result_valid    = ctl[BLOCK_BITS].valid;
	assign range_error     = ctl[BLOCK_BITS].err;
	assign max_position    = pos[BLOCK_BITS];

	`BRMP_ASSERT(a_err_pos_zero, clk, arst_n,
		(result_valid && range_error) |-> (max_position == '0))
	`BRMP_ASSERT(a_full_row_only, clk, arst_n,
		!query_ready |-> (result_valid && !result_ready))
	`BRMP_ASSERT(a_accept_lands, clk, arst_n,
		(query_valid && query_ready) |=> ctl[1].valid)
	`BRMP_ASSERT(a_result_held, clk, arst_n,
		(result_valid && !result_ready) |=> result_valid)
	`BRMP_ASSERT_ALWAYS(a_reset_empty, clk,
		!arst_n |=> !result_valid)

endmodule
